// ----- sv/fpba_pkg.sv -----
// Shared types and constants for the fit-policy block allocator.
// No dependencies; every other file imports this package.
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam int OP_W       = 1;
    localparam int BIDX_W     = 4;
    localparam int AMT_W      = 32;
    localparam int BNUM_W     = 5;
    localparam int POLICY_W   = 2;
    localparam int BLKS_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int LIM_W      = (CNT_W > BLKS_W) ? CNT_W : BLKS_W;

    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [BLKS_W-1:0] BLOCKS_RESET = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ----- sv/fpba_req_if.sv -----
// Request channel: valid/ready handshake with one input item as payload.
// Depends on fpba_pkg.
interface fpba_req_if import fpba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] block_index;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, op, block_index, amount, input ready);
    modport sink   (input valid, op, block_index, amount, output ready);
endinterface

// ----- sv/fpba_rsp_if.sv -----
// Response channel: valid/ready handshake with one result item as payload.
// Depends on fpba_pkg.
interface fpba_rsp_if import fpba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [BNUM_W-1:0] block_number;
    logic [AMT_W-1:0]  remaining_after;

    modport source (output valid, granted, block_number, remaining_after, input ready);
    modport sink   (input valid, granted, block_number, remaining_after, output ready);
endinterface

// ----- sv/fit_policy_block_allocator.sv -----
// Fit-policy block allocator: first, best or worst fit over a table of
// sixteen block capacities.
//
// Channels: i_req carries op, block_index and amount; o_rsp carries granted,
// block_number and remaining_after. Both transfer when valid and ready are
// high at a rising edge. A load (op 0) sets one block's capacity; a request
// (op 1) picks a fitting block among the first blocks_in_use blocks, takes
// the amount from it and returns its 1-based number, or 0 if none fits.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 fit_policy, 1 blocks_in_use); write only while the block is idle.
//
// Flow: one item at a time. A request walks n table entries from entry 0,
// n being min(blocks_in_use, 16), so 16 at most, one entry per cycle through a
// single compare-and-select; a load skips the walk. i_req.ready is high only
// while idle, so the next item can transfer in the cycle after the result is
// registered.
// Reset clears the whole table to zero capacity at once, sets fit_policy
// to first fit and blocks_in_use to 16, and empties the result register.
// If the receiver stalls, the result holds in the output register; the
// next item may transfer in, but its result waits until the slot frees.
module fit_policy_block_allocator import fpba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpba_req_if.sink              i_req,
    fpba_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fpba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_req.op),
        .i_block_index     (i_req.block_index),
        .i_amount          (i_req.amount),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_granted         (o_rsp.granted),
        .o_block_number    (o_rsp.block_number),
        .o_remaining_after (o_rsp.remaining_after)
    );

endmodule

// ----- sv/fpba_ctrl.sv -----
// Controller state machine: accept, scan the capacity table, finish.
// Depends on fpba_pkg.
module fpba_ctrl import fpba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // a load skips the table walk
                if (i_status.is_load || i_status.scan_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/fpba_dp.sv -----
// Datapath: capacity table, config registers, scan pointer, pick tracking
// and the output register. Depends on fpba_pkg.
module fpba_dp import fpba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [OP_W-1:0]       i_op,
    input  logic [BIDX_W-1:0]     i_block_index,
    input  logic [AMT_W-1:0]      i_amount,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_granted,
    output logic [BNUM_W-1:0]     o_block_number,
    output logic [AMT_W-1:0]      o_remaining_after
);

    logic [AMT_W-1:0]    r_cap [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;

    logic [POLICY_W-1:0] r_policy;
    logic [BLKS_W-1:0]   r_blocks;

    logic [OP_W-1:0]     r_op;
    logic [BIDX_W-1:0]   r_idx;
    logic [AMT_W-1:0]    r_amount;
    logic [CNT_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_scan;
    logic                r_found;
    logic [IDX_W-1:0]    r_pick;
    logic [AMT_W-1:0]    r_pick_cap;

    logic                r_out_valid;
    logic                r_granted;
    logic [BNUM_W-1:0]   r_block_number;
    logic [AMT_W-1:0]    r_remaining;

    logic [IDX_W-1:0]    scan_idx;
    logic [AMT_W-1:0]    cur_cap;
    logic                fits;
    logic                take;
    logic [CNT_W-1:0]    n_limit;
    logic                load_ok;
    logic [AMT_W-1:0]    left;

    assign scan_idx = r_scan[IDX_W-1:0];
    assign cur_cap  = r_vld[scan_idx] ? r_cap[scan_idx] : '0;
    assign fits     = (cur_cap >= r_amount);
    assign take     = fits && (!r_found
                      || (r_policy == POLICY_BEST  && cur_cap < r_pick_cap)
                      || (r_policy == POLICY_WORST && cur_cap > r_pick_cap));

    // clamp the block count to the table size
    assign n_limit = (LIM_W'(r_blocks) > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                             : CNT_W'(r_blocks);
    assign load_ok = (32'(r_idx) < 32'(NUM_BLOCKS));
    assign left    = r_pick_cap - r_amount;

    assign o_status.is_load   = (r_op == OP_LOAD);
    assign o_status.scan_done = (r_scan == r_limit);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_FIRST;
            r_blocks <= BLOCKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIT_POLICY:    r_policy <= i_cfg_wdata[POLICY_W-1:0];
                CFG_BLOCKS_IN_USE: r_blocks <= i_cfg_wdata[BLKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // item capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_idx    <= i_block_index;
            r_amount <= i_amount;
            r_limit  <= n_limit;
            r_scan   <= '0;
            r_found  <= 1'b0;
        end else if (i_cmd.step) begin
            r_scan <= r_scan + 1'b1;
            if (take) begin
                r_found    <= 1'b1;
                r_pick     <= scan_idx;
                r_pick_cap <= cur_cap;
            end
        end
    end

    // table write happens at most once per item, at finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.finish) begin
            if (r_op == OP_LOAD) begin
                if (load_ok) begin
                    r_vld[r_idx[IDX_W-1:0]] <= 1'b1;
                end
            end else if (r_found) begin
                r_vld[r_pick] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_op == OP_LOAD) begin
                if (load_ok) begin
                    r_cap[r_idx[IDX_W-1:0]] <= r_amount;
                end
            end else if (r_found) begin
                r_cap[r_pick] <= left;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_op == OP_LOAD) begin
                r_granted      <= 1'b0;
                r_block_number <= '0;
                r_remaining    <= load_ok ? r_amount : '0;
            end else if (r_found) begin
                r_granted      <= 1'b1;
                r_block_number <= BNUM_W'(r_pick) + 1'b1;
                r_remaining    <= left;
            end else begin
                r_granted      <= 1'b0;
                r_block_number <= '0;
                r_remaining    <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_granted;
    assign o_block_number    = r_block_number;
    assign o_remaining_after = r_remaining;

endmodule

// ----- sv/fpba_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
// Depends on fpba_pkg.
module fpba_checker import fpba_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_granted,
    input logic [BNUM_W-1:0] i_block_number
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_grant_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_granted |->
            i_block_number != '0 && i_block_number <= BNUM_W'(NUM_BLOCKS))
        else $error("granted result without a valid block number");

    a_deny_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_granted |-> i_block_number == '0)
        else $error("ungranted result names a block");

    // one item in flight: no transfer right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second item taken while busy");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result present after reset");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_granted      (o_rsp.granted),
    .i_block_number (o_rsp.block_number)
);

// ----- test/fit_policy_block_allocator_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for fit_policy_block_allocator: loads and requests under each fit policy.
// Depends on fpba_pkg, fpba_req_if, fpba_rsp_if and the allocator RTL.
module fit_policy_block_allocator_test;
    import fpba_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int MAX_WAIT        = 8;
    localparam int DRAIN_CYCLES    = 25;

    // fit_policy code with no policy of its own; behaves as first fit
    localparam logic [POLICY_W-1:0] POLICY_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BIDX_W-1:0] block_index;
        logic [AMT_W-1:0]  amount;
    } t_alloc_item;

    typedef struct packed {
        logic              granted;
        logic [BNUM_W-1:0] block_number;
        logic [AMT_W-1:0]  remaining_after;
    } t_alloc_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fpba_req_if alloc_req ();
    fpba_rsp_if alloc_rsp ();

    fit_policy_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (alloc_req),
        .o_rsp       (alloc_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow of the allocator: capacity table and its two registers
    logic [AMT_W-1:0]    capacity_tbl [NUM_BLOCKS];
    logic [POLICY_W-1:0] policy_sel;
    logic [BLKS_W-1:0]   blocks_sel;

    t_alloc_item   pending_items [$];
    t_alloc_result expected_results [$];

    t_alloc_item   next_item;
    t_alloc_item   taken_item;
    t_alloc_result want;
    logic          req_fire = 1'b0;
    logic          rsp_fire = 1'b0;
    logic          rsp_armed = 1'b0;
    int            req_hold = 0;
    int            rsp_hold = 0;
    int            req_calm = 0;
    int            rsp_calm = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int considered_blocks();
        return (blocks_sel > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_sel);
    endfunction

    // Apply one item to the shadow table and return the result it must produce.
    function automatic t_alloc_result predict_allocation(t_alloc_item it);
        t_alloc_result r;
        int            pick;
        r    = '0;
        pick = -1;
        if (it.op == OP_LOAD) begin
            if (it.block_index < NUM_BLOCKS) begin
                capacity_tbl[it.block_index] = it.amount;
                r.remaining_after = it.amount;
            end
        end else begin
            for (int k = 0; k < considered_blocks(); k++) begin
                if (capacity_tbl[k] >= it.amount) begin
                    if (pick < 0) begin
                        pick = k;
                    end else if (policy_sel == POLICY_BEST) begin
                        if (capacity_tbl[k] < capacity_tbl[pick]) pick = k;
                    end else if (policy_sel == POLICY_WORST) begin
                        if (capacity_tbl[k] > capacity_tbl[pick]) pick = k;
                    end
                end
            end
            if (pick >= 0) begin
                capacity_tbl[pick] = capacity_tbl[pick] - it.amount;
                r.granted         = 1'b1;
                r.block_number    = BNUM_W'(pick + 1);
                r.remaining_after = capacity_tbl[pick];
            end
        end
        return r;
    endfunction

    // Mostly random waits, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Multiples of 16 make equal capacities common, so tie-breaks get exercised.
    function automatic logic [AMT_W-1:0] draw_capacity();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3: return AMT_W'(1) << $urandom_range(0, AMT_W - 1);
            default: return AMT_W'($urandom_range(1, 16) * 16);
        endcase
    endfunction

    function automatic logic [AMT_W-1:0] draw_size();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3: return AMT_W'($urandom_range(0, 5000));
            default: return AMT_W'($urandom_range(0, 120));
        endcase
    endfunction

    // When the window is not empty, at least half the loads land inside the considered window.
    function automatic logic [BIDX_W-1:0] draw_block();
        int n;
        n = considered_blocks();
        if (n > 0 && $urandom_range(0, 1) == 1) return BIDX_W'($urandom_range(0, n - 1));
        return BIDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [BIDX_W-1:0] idx,
                              input logic [AMT_W-1:0] amt);
        pending_items.push_back('{op: op, block_index: idx, amount: amt});
    endtask

    // Mostly a batch of loads followed by requests against them; some pure noise.
    task automatic fill_phase(input int count);
        int added;
        int loads;
        int asks;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 7) != 0) begin
                loads = $urandom_range(1, 8);
                asks  = $urandom_range(2, 10);
                repeat (loads) queue_item(OP_LOAD, draw_block(), draw_capacity());
                repeat (asks) queue_item(OP_REQUEST, draw_block(), draw_size());
                added += loads + asks;
            end else begin
                repeat (4) queue_item(OP_W'($urandom_range(0, 1)),
                                      BIDX_W'($urandom_range(0, NUM_BLOCKS - 1)), $urandom());
                added += 4;
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIT_POLICY) policy_sel = data[POLICY_W-1:0];
        else if (idx == CFG_BLOCKS_IN_USE) blocks_sel = data[BLKS_W-1:0];
    endtask

    // Idle: nothing queued or offered, every result back, and the block taking items.
    task automatic wait_idle();
        while (pending_items.size() != 0 || alloc_req.valid || expected_results.size() != 0
               || !alloc_req.ready)
            @(posedge i_clk);
    endtask

    // Drivers: request and response ready, updated on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!alloc_req.valid || req_fire) begin
                if (req_hold > 0) begin
                    alloc_req.valid <= 1'b0;
                    req_hold--;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    alloc_req.valid       <= 1'b1;
                    alloc_req.op          <= next_item.op;
                    alloc_req.block_index <= next_item.block_index;
                    alloc_req.amount      <= next_item.amount;
                    req_hold = draw_wait(req_calm);
                end else begin
                    alloc_req.valid <= 1'b0;
                end
            end

            // stall each result for its own drawn wait
            if (rsp_fire) rsp_armed = 1'b0;
            if (alloc_rsp.valid && !rsp_armed) begin
                rsp_armed = 1'b1;
                rsp_hold  = draw_wait(rsp_calm);
            end
            if (rsp_armed && rsp_hold > 0) begin
                alloc_rsp.ready <= 1'b0;
                rsp_hold--;
            end else begin
                alloc_rsp.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each request transfer, check on each result transfer.
    always @(posedge i_clk) begin
        req_fire <= alloc_req.valid && alloc_req.ready;
        rsp_fire <= alloc_rsp.valid && alloc_rsp.ready;
        if (i_rst_n) begin
            if (alloc_req.valid && alloc_req.ready) begin
                taken_item.op          = alloc_req.op;
                taken_item.block_index = alloc_req.block_index;
                taken_item.amount      = alloc_req.amount;
                expected_results.push_back(predict_allocation(taken_item));
            end
            if (alloc_rsp.valid && alloc_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: granted %0d block_number %0d remaining_after %h",
                           alloc_rsp.granted, alloc_rsp.block_number, alloc_rsp.remaining_after);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (alloc_rsp.granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, alloc_rsp.granted);
                        mismatches++;
                    end
                    if (alloc_rsp.block_number !== want.block_number) begin
                        $error("block_number: expected %0d, got %0d",
                               want.block_number, alloc_rsp.block_number);
                        mismatches++;
                    end
                    if (alloc_rsp.remaining_after !== want.remaining_after) begin
                        $error("remaining_after: expected %h, got %h",
                               want.remaining_after, alloc_rsp.remaining_after);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [POLICY_W-1:0] policy_plan [8];
        logic [BLKS_W-1:0]   blocks_plan [8];
        logic [POLICY_W-1:0] policy_pick;
        logic [BLKS_W-1:0]   blocks_pick;

        policy_plan = '{POLICY_WORST, POLICY_FIRST, POLICY_UNUSED, POLICY_BEST,
                        POLICY_WORST, POLICY_BEST, POLICY_FIRST, POLICY_BEST};
        blocks_plan = '{5'd16, 5'd0, 5'd16, 5'd1, 5'd31, 5'd17, 5'd5, 5'd2};

        alloc_req.valid       = 1'b0;
        alloc_req.op          = OP_LOAD;
        alloc_req.block_index = '0;
        alloc_req.amount      = '0;
        alloc_rsp.ready       = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = CFG_FIT_POLICY;
        i_cfg_wdata           = '0;
        for (int k = 0; k < NUM_BLOCKS; k++) capacity_tbl[k] = '0;
        policy_sel = POLICY_FIRST;
        blocks_sel = BLOCKS_RESET;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: first fit over all sixteen blocks, empty table.
        queue_item(OP_REQUEST, 4'd0, '0);             // zero size fits an empty block
        queue_item(OP_REQUEST, 4'd0, 32'd1);          // nothing fits
        queue_item(OP_LOAD, 4'd0, '1);
        queue_item(OP_LOAD, 4'd15, '1);
        queue_item(OP_LOAD, 4'd6, 32'hAAAA_AAAA);
        queue_item(OP_LOAD, 4'd9, 32'h5555_5555);
        queue_item(OP_REQUEST, 4'd15, '1);            // drains block 1 to zero
        queue_item(OP_REQUEST, 4'd0, '1);             // only block 16 is left that large
        queue_item(OP_REQUEST, 4'd0, 32'h5555_5556);
        queue_item(OP_LOAD, 4'd3, 32'd100);
        queue_item(OP_LOAD, 4'd5, 32'd100);
        queue_item(OP_REQUEST, 4'd0, 32'd40);
        queue_item(OP_REQUEST, 4'd0, '0);
        wait_idle();

        // Best fit with a tie between two equal capacities, then worst fit.
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
        queue_item(OP_LOAD, 4'd2, 32'd60);
        queue_item(OP_REQUEST, 4'd0, 32'd60);
        queue_item(OP_REQUEST, 4'd0, 32'd50);
        wait_idle();
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_WORST));
        queue_item(OP_REQUEST, 4'd0, 32'd10);
        queue_item(OP_REQUEST, 4'd0, '0);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                policy_pick = policy_plan[p];
                blocks_pick = blocks_plan[p];
            end else begin
                policy_pick = POLICY_W'($urandom_range(0, 3));
                blocks_pick = ($urandom_range(0, 3) == 0) ? BLKS_W'($urandom_range(0, 31))
                                                          : BLKS_W'($urandom_range(1, 16));
            end
            wait_idle();
            write_register(CFG_FIT_POLICY, CFG_DATA_W'(policy_pick));
            write_register(CFG_BLOCKS_IN_USE, CFG_DATA_W'(blocks_pick));
            fill_phase(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
